FILE: hdl/lzss_pkg.sv
package lzss_pkg;

  // history window geometry
  localparam int unsigned WIN_AW         = 12;
  localparam int unsigned WIN_DEPTH      = 1 << WIN_AW;
  localparam int unsigned START_POSITION = 4078;
  localparam logic [WIN_AW-1:0] START_ADDR = WIN_AW'(START_POSITION);

  // match length counter: low nibble plus three, at most 18
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned LEN_BIAS = 3;

  // controller to datapath commands
  typedef struct packed {
    logic clear_wr;   // zero one window entry, step the clear address
    logic lit_wr;     // literal: write window, load output word
    logic low_load;   // keep low position byte of a match
    logic run_start;  // load match source address and length
    logic rd_issue;   // read window at source address
    logic e_emit;     // write fetched byte back and load output word
    logic e_last;     // fetched byte is the final one of the run
  } lzss_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;   // output register can take a word this cycle
    logic rem_zero;   // no bytes left to fetch
    logic rem_one;    // one byte left to fetch
    logic clr_last;   // clear pass at its final entry
  } lzss_stat_t;

endpackage

FILE: hdl/lzss_window_decoder_unit.sv
// LZSS decoder with a 4096-byte history window.
// Input channel: one compressed word per handshake (in_byte, with
// in_end_of_stream on the final word of a stream). Output channel: one
// decompressed word per handshake; out_last_of_run marks the final word
// produced by an input word.
// Flag words and match low bytes produce no output. A literal's word is in
// the output register the cycle after the literal is accepted. A match high
// byte with a run of N bytes (3 to 18) occupies the block from its accepting
// cycle through one window read per byte on the read port, each fetched byte
// registered, then written back and loaded into the output register once
// that register is free.
// After reset, and after the input word carrying end of stream has been
// fully decoded, the block zeroes all 4096 window entries in a clearing pass,
// during which in_stall is high. A pending output word is still delivered
// during that pass.
// When the receiver asserts out_stall, the output word holds; a match run
// pauses in place and in_stall stays high until the output register frees.
module lzss_window_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);
  import lzss_pkg::*;

  lzss_cmd_t  cmd;
  lzss_stat_t stat;

  // decode sequencing
  lzss_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .stat             (stat),
    .cmd              (cmd)
  );

  // window, counters and output register
  lzss_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: hdl/lzss_dpath.sv
module lzss_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  lzss_pkg::lzss_cmd_t  cmd,
  output lzss_pkg::lzss_stat_t stat,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last_of_run
);
  import lzss_pkg::*;

  logic [7:0]        mem [0:WIN_DEPTH-1];
  logic [7:0]        rd_data_r;
  logic              byp_r;
  logic [7:0]        byp_data_r;
  logic [WIN_AW-1:0] wp_r, wp_nxt;
  logic [WIN_AW-1:0] src_r, src_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [WIN_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [7:0]        low_r;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r;
  logic              out_last_r;

  logic              wr_en;
  logic [WIN_AW-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [7:0]        fetch_byte;
  logic [11:0]       run_pos;

  // fetched byte, forwarded when the read hit the entry written that cycle
  assign fetch_byte = byp_r ? byp_data_r : rd_data_r;
  assign run_pos    = {in_byte[7:4], low_r};

  // single window write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wp_r;
    wr_data = 8'h00;
    priority if (cmd.clear_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
    end else if (cmd.lit_wr) begin
      wr_en   = 1'b1;
      wr_data = in_byte;
    end else if (cmd.e_emit) begin
      wr_en   = 1'b1;
      wr_data = fetch_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r  <= mem[src_r];
      byp_r      <= wr_en && (wr_addr == src_r);
      byp_data_r <= wr_data;
    end
  end

  // address, length and clear counters
  always_comb begin
    wp_nxt       = wp_r;
    src_nxt      = src_r;
    rem_nxt      = rem_r;
    clr_addr_nxt = clr_addr_r;
    if (cmd.clear_wr) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      wp_nxt       = START_ADDR;
    end
    if (cmd.lit_wr || cmd.e_emit) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (cmd.run_start) begin
      src_nxt = WIN_AW'(run_pos);
      rem_nxt = {1'b0, in_byte[3:0]} + LEN_W'(LEN_BIAS);
    end else if (cmd.rd_issue) begin
      src_nxt = src_r + 1'b1;
      rem_nxt = rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= START_ADDR;
      rem_r      <= '0;
      clr_addr_r <= '0;
    end else begin
      wp_r       <= wp_nxt;
      rem_r      <= rem_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    if (cmd.low_load) begin
      low_r <= in_byte;
    end
  end

  // output word register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.lit_wr || cmd.e_emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lit_wr) begin
      out_byte_r <= in_byte;
      out_last_r <= 1'b1;
    end else if (cmd.e_emit) begin
      out_byte_r <= fetch_byte;
      out_last_r <= cmd.e_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.rem_zero = (rem_r == '0);
  assign stat.rem_one  = (rem_r == LEN_W'(1));
  assign stat.clr_last = &clr_addr_r;

endmodule

FILE: hdl/lzss_ctrl.sv
module lzss_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  logic                 in_end_of_stream,
  input  lzss_pkg::lzss_stat_t stat,
  output lzss_pkg::lzss_cmd_t  cmd
);
  import lzss_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_MATCH = 2'd2;

  localparam logic [1:0] PH_SHIFT = 2'd0;
  localparam logic [1:0] PH_ITEM  = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] flag_r, flag_nxt;
  logic        eos_pend_r, eos_pend_nxt;
  logic        e_valid_r, e_valid_nxt;
  logic        e_last_r, e_last_nxt;

  logic        accept;
  logic [15:0] flag_shifted;
  logic [15:0] flag_cur;

  assign in_stall     = !((state_r == ST_IDLE) && stat.out_free);
  assign accept       = in_valid && !in_stall;
  assign flag_shifted = {1'b0, flag_r[15:1]};
  assign flag_cur     = (phase_r == PH_ITEM) ? flag_r : flag_shifted;

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    flag_nxt     = flag_r;
    eos_pend_nxt = eos_pend_r;
    e_valid_nxt  = e_valid_r;
    e_last_nxt   = e_last_r;
    cmd          = '0;

    unique case (state_r)
      // zero the window one entry a cycle
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end

      // decode one compressed word
      ST_IDLE: begin
        if (accept) begin
          if (phase_r == PH_HIGH) begin
            cmd.run_start = 1'b1;
            phase_nxt     = PH_SHIFT;
            eos_pend_nxt  = in_end_of_stream;
            e_valid_nxt   = 1'b0;
            state_nxt     = ST_MATCH;
          end else if ((phase_r != PH_ITEM) && !flag_shifted[8]) begin
            // new flag word, marker ones above it
            flag_nxt  = {8'hFF, in_byte};
            phase_nxt = PH_ITEM;
          end else begin
            flag_nxt = flag_cur;
            if (flag_cur[0]) begin
              cmd.lit_wr = 1'b1;
              phase_nxt  = PH_SHIFT;
            end else begin
              cmd.low_load = 1'b1;
              phase_nxt    = PH_HIGH;
            end
          end
          if (in_end_of_stream && (phase_r != PH_HIGH)) begin
            flag_nxt  = '0;
            phase_nxt = PH_SHIFT;
            state_nxt = ST_CLEAR;
          end
        end
      end

      // copy run: fetch one byte while the previous one is written back
      ST_MATCH: begin
        cmd.e_emit   = e_valid_r && stat.out_free;
        cmd.e_last   = e_last_r;
        cmd.rd_issue = !stat.rem_zero && (!e_valid_r || stat.out_free);
        if (cmd.rd_issue) begin
          e_valid_nxt = 1'b1;
          e_last_nxt  = stat.rem_one;
        end else if (cmd.e_emit) begin
          e_valid_nxt = 1'b0;
        end
        if (cmd.e_emit && e_last_r) begin
          if (eos_pend_r) begin
            flag_nxt  = '0;
            phase_nxt = PH_SHIFT;
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      phase_r    <= PH_SHIFT;
      flag_r     <= '0;
      eos_pend_r <= 1'b0;
      e_valid_r  <= 1'b0;
      e_last_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      flag_r     <= flag_nxt;
      eos_pend_r <= eos_pend_nxt;
      e_valid_r  <= e_valid_nxt;
      e_last_r   <= e_last_nxt;
    end
  end

endmodule

FILE: verif/lzss_window_decoder_unit_test.sv
`timescale 1ns / 1ps

module lzss_window_decoder_unit_test;
  import lzss_pkg::*;

  localparam int RANDOM_WORDS   = 220;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [15:0] FLAG_MARKER = 16'hFF00;

  // decoder phase: shift flags, item under a fresh flag, match high byte
  typedef enum logic [1:0] {
    PHASE_SHIFT    = 2'd0,
    PHASE_ITEM     = 2'd1,
    PHASE_MATCH_HI = 2'd2
  } decode_phase_t;

  typedef struct {
    logic [7:0] value;
    logic       eos;
  } comp_word_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } plain_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last_of_run;

  lzss_window_decoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run)
  );

  always #1 clk = ~clk;

  // shadow decoder state
  logic [7:0]    history [WIN_DEPTH];
  logic [11:0]   write_addr;
  logic [15:0]   flag_bits;
  decode_phase_t phase;
  logic [7:0]    match_low;

  comp_word_t  compressed_words [$];
  plain_word_t decoded_bytes [$];

  int  errors = 0;
  int  words_in = 0;
  int  words_out = 0;
  int  literals = 0;
  int  match_runs = 0;
  int  streams_closed = 0;
  int  idle_cycles = 0;
  int  in_wait = 0;
  int  out_hold = 0;
  bit  in_taken = 1'b0;
  bit  in_quiet = 1'b0;
  bit  out_quiet = 1'b1;

  function automatic void clear_decoder();
    for (int i = 0; i < WIN_DEPTH; i++) history[i] = 8'h00;
    write_addr = START_ADDR;
    flag_bits  = 16'h0000;
    phase      = PHASE_SHIFT;
    match_low  = 8'h00;
  endfunction

  function automatic void emit_byte(input logic [7:0] c);
    history[write_addr] = c;
    write_addr = write_addr + 12'd1;
    decoded_bytes.push_back('{value: c, last: 1'b0});
  endfunction

  // expected output words for one accepted compressed word
  function automatic void decode_word(input logic [7:0] b, input logic eos);
    logic [15:0] shifted;
    logic [11:0] src;
    int          run_len;
    int          produced;
    int          k;
    bit          take_item;
    produced = 0;
    if (phase == PHASE_MATCH_HI) begin
      src = {b[7:4], match_low};
      run_len = int'(b[3:0]) + LEN_BIAS;
      // byte at a time so an overlapping run sees its own output
      for (k = 0; k < run_len; k++) begin
        emit_byte(history[src]);
        src = src + 12'd1;
        produced++;
      end
      phase = PHASE_SHIFT;
      match_runs++;
    end else begin
      take_item = 1'b1;
      if (phase != PHASE_ITEM) begin
        shifted = flag_bits >> 1;
        if (!shifted[8]) begin
          flag_bits = FLAG_MARKER | {8'h00, b};
          phase = PHASE_ITEM;
          take_item = 1'b0;
        end else begin
          flag_bits = shifted;
        end
      end
      if (take_item) begin
        if (flag_bits[0]) begin
          emit_byte(b);
          produced++;
          literals++;
          phase = PHASE_SHIFT;
        end else begin
          match_low = b;
          phase = PHASE_MATCH_HI;
        end
      end
    end
    if (produced > 0) decoded_bytes[decoded_bytes.size()-1].last = 1'b1;
    if (eos) begin
      clear_decoder();
      streams_closed++;
    end
  endfunction

  // wait length per word, with runs of back-to-back traffic
  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 29) == 0) quiet = !quiet;
    return quiet ? 0 : int'($urandom_range(0, 9));
  endfunction

  task automatic add_word(input logic [7:0] b, input logic eos);
    compressed_words.push_back('{value: b, eos: eos});
  endtask

  // well-formed stream cut off with end of stream after target words
  task automatic make_stream(input int target);
    int          cnt;
    int          k;
    logic [7:0]  fl;
    logic [11:0] gwp;
    logic [11:0] pos;
    logic [3:0]  ln;
    cnt = 0;
    gwp = START_ADDR;
    while (cnt < target) begin
      if ($urandom_range(0, 4) == 0) fl = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      else fl = 8'($urandom);
      add_word(fl, 1'b0);
      cnt++;
      for (k = 0; k < 8 && cnt < target; k++) begin
        if (fl[k]) begin
          add_word(8'($urandom), 1'b0);
          cnt++;
          gwp = gwp + 12'd1;
        end else begin
          ln = 4'($urandom);
          // mostly recent history, often overlapping the run itself
          if ($urandom_range(0, 4) < 3) pos = gwp - 12'($urandom_range(1, 24));
          else pos = 12'($urandom);
          add_word(pos[7:0], 1'b0);
          cnt++;
          if (cnt < target) begin
            add_word({pos[11:8], ln}, 1'b0);
            cnt++;
          end
          gwp = gwp + 12'(ln) + 12'd3;
        end
      end
    end
    compressed_words[compressed_words.size()-1].eos = 1'b1;
  endtask

  // accept side of the input channel
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      decode_word(in_byte, in_end_of_stream);
      in_taken = 1'b1;
      words_in++;
    end
  end

  // input driver
  always @(negedge clk) begin : feed_p
    logic       drive;
    comp_word_t nxt;
    if (rst_n) begin
      drive = in_valid;
      if (in_taken) begin
        drive = 1'b0;
        in_taken = 1'b0;
      end
      if (!drive && compressed_words.size() > 0) begin
        if (in_wait > 0) begin
          in_wait--;
        end else begin
          nxt = compressed_words.pop_front();
          in_byte <= nxt.value;
          in_end_of_stream <= nxt.eos;
          drive = 1'b1;
          in_wait = draw_gap(in_quiet);
        end
      end
      in_valid <= drive;
    end
  end

  // output monitor and checker
  always @(posedge clk) begin : check_p
    plain_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_out++;
      if (decoded_bytes.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual byte %h last %b",
                 $time, out_byte, out_last_of_run);
        errors++;
      end else begin
        want = decoded_bytes.pop_front();
        if (out_byte !== want.value) begin
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, want.value, out_byte);
          errors++;
        end
        if (out_last_of_run !== want.last) begin
          $display("%0t: out_last_of_run mismatch: expected %b, actual %b",
                   $time, want.last, out_last_of_run);
          errors++;
        end
      end
      out_hold = draw_gap(out_quiet);
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus_p
    int random_start;
    int n;
    clear_decoder();

    // flags 0x53: literal, literal, match, match, literal, match, literal, match
    add_word(8'h53, 1'b0);
    add_word(8'h00, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(8'hEE, 1'b0);  // overlapping run at the start position
    add_word(8'hF0, 1'b0);
    add_word(8'hFF, 1'b0);  // longest run, wraps past the window end
    add_word(8'hFF, 1'b0);
    add_word(8'h80, 1'b0);
    add_word(8'h00, 1'b0);
    add_word(8'h0F, 1'b0);
    add_word(8'h7F, 1'b0);
    add_word(8'h12, 1'b1);  // stream cut on a match low byte
    add_word(8'hA5, 1'b1);  // stream cut on a flag word
    add_word(8'hFF, 1'b0);
    add_word(8'h55, 1'b0);
    add_word(8'hAA, 1'b1);  // end on a literal
    add_word(8'h00, 1'b0);
    add_word(8'h34, 1'b0);
    add_word(8'h4C, 1'b1);  // end on a match

    // random streams, a few of them raw noise
    random_start = compressed_words.size();
    while (compressed_words.size() - random_start < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(5, 20);
        for (int i = 0; i < n; i++) add_word(8'($urandom), i == n - 1);
      end else begin
        make_stream($urandom_range(15, 60));
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (compressed_words.size() > 0 || in_valid) @(posedge clk);
    while (decoded_bytes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d compressed words in, %0d decoded words out, %0d mismatches",
             words_in, words_out, errors);
    $display("run: %0d literals, %0d match runs, %0d streams closed by end of stream",
             literals, match_runs, streams_closed);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/lzss_pkg.sv
hdl/lzss_dpath.sv
hdl/lzss_ctrl.sv
hdl/lzss_window_decoder_unit.sv
verif/lzss_window_decoder_unit_test.sv
